[hdl/cart_mode_sequencer_with_watchdog_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef CART_MODE_SEQUENCER_WITH_WATCHDOG_MACROS_SVH
`define CART_MODE_SEQUENCER_WITH_WATCHDOG_MACROS_SVH

// same-cycle implication
`define CMSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cmsw_pkg.sv]
// ----------------------------------------------------------------------------
// cmsw_pkg
// Types, codes and reset values shared by the cart mode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmsw_pkg;

  // operating modes
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_ALARM  = 2'd2;

  // stage codes
  localparam logic [3:0] STG_IDLE     = 4'd0;
  localparam logic [3:0] STG_LEFT     = 4'd1;
  localparam logic [3:0] STG_MID_RUN  = 4'd5;
  localparam logic [3:0] STG_MID_SEEN = 4'd6;
  localparam logic [3:0] STG_MID_BACK = 4'd8;
  localparam logic [3:0] STG_RIGHT    = 4'd10;

  // configuration register indexes
  localparam logic [2:0] CFG_FULL_SPEED   = 3'd0;
  localparam logic [2:0] CFG_JOG_SPEED    = 3'd1;
  localparam logic [2:0] CFG_ALARM_TMO    = 3'd2;
  localparam logic [2:0] CFG_LEFT_THR     = 3'd3;
  localparam logic [2:0] CFG_MIDDLE_LOW   = 3'd4;
  localparam logic [2:0] CFG_MIDDLE_HIGH  = 3'd5;
  localparam logic [2:0] CFG_RIGHT_THR    = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int TICK_W     = 14;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // reset values
  localparam logic [7:0]  RST_FULL_SPEED  = 8'd140;
  localparam logic [7:0]  RST_JOG_SPEED   = 8'd99;
  localparam logic [12:0] RST_ALARM_TMO   = 13'd4000;
  localparam logic [7:0]  RST_LEFT_THR    = 8'd75;
  localparam logic [7:0]  RST_MIDDLE_LOW  = 8'd95;
  localparam logic [7:0]  RST_MIDDLE_HIGH = 8'd175;
  localparam logic [7:0]  RST_RIGHT_THR   = 8'd195;
  localparam logic [7:0]  RST_PWM_HOLD    = 8'd159;

  typedef struct packed {
    logic       mode_switch;
    logic       mode_event;
    logic       button_left;
    logic       button_middle;
    logic       button_right;
    logic       left_end;
    logic       right_end;
    logic       middle_sensor;
    logic       jog_left;
    logic       jog_right;
    logic [7:0] analog_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] stage;
    logic       drive_left;
    logic       drive_right;
    logic [7:0] pwm_compare;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  full_speed;
    logic [7:0]  jog_speed;
    logic [12:0] alarm_timeout;
    logic [7:0]  left_threshold;
    logic [7:0]  middle_low;
    logic [7:0]  middle_high;
    logic [7:0]  right_threshold;
  } cfg_t;

  // progression of a running stage from the position sensors
  function automatic logic [3:0] stage_advance(input logic [3:0] st,
                                               input logic le,
                                               input logic re,
                                               input logic mid);
    logic [3:0] nxt;
    nxt = st;
    case (st)
      STG_LEFT:     nxt = le ? STG_IDLE : STG_LEFT;
      STG_MID_RUN:  nxt = mid ? STG_MID_SEEN : (re ? STG_MID_BACK : STG_MID_RUN);
      STG_MID_SEEN: nxt = mid ? STG_MID_SEEN : STG_MID_BACK;
      STG_MID_BACK: nxt = mid ? STG_IDLE : STG_MID_BACK;
      STG_RIGHT:    nxt = re ? STG_IDLE : STG_RIGHT;
      default:      nxt = st;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

[hdl/cmsw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cmsw_cfg_regs
// Configuration register file; one write per cycle, unknown indexes dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module cmsw_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cmsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cmsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cmsw_pkg::cfg_t                        cfg
);
  import cmsw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FULL_SPEED:  cfg_nxt.full_speed      = cfg_data[7:0];
        CFG_JOG_SPEED:   cfg_nxt.jog_speed       = cfg_data[7:0];
        CFG_ALARM_TMO:   cfg_nxt.alarm_timeout   = cfg_data[12:0];
        CFG_LEFT_THR:    cfg_nxt.left_threshold  = cfg_data[7:0];
        CFG_MIDDLE_LOW:  cfg_nxt.middle_low      = cfg_data[7:0];
        CFG_MIDDLE_HIGH: cfg_nxt.middle_high     = cfg_data[7:0];
        CFG_RIGHT_THR:   cfg_nxt.right_threshold = cfg_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_speed      <= RST_FULL_SPEED;
      cfg_r.jog_speed       <= RST_JOG_SPEED;
      cfg_r.alarm_timeout   <= RST_ALARM_TMO;
      cfg_r.left_threshold  <= RST_LEFT_THR;
      cfg_r.middle_low      <= RST_MIDDLE_LOW;
      cfg_r.middle_high     <= RST_MIDDLE_HIGH;
      cfg_r.right_threshold <= RST_RIGHT_THR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/cmsw_core.sv]
// ----------------------------------------------------------------------------
// cmsw_core
// Mode, stage machines, move watchdog and PWM hold; one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cart_mode_sequencer_with_watchdog_macros.svh"

module cmsw_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire cmsw_pkg::in_item_t  item,
  input  wire cmsw_pkg::cfg_t      cfg,
  output cmsw_pkg::out_item_t      res
);
  import cmsw_pkg::*;

  logic [1:0]        mode_r,  mode_nxt;
  logic [3:0]        man_stage_r, man_stage_nxt;
  logic [3:0]        auto_stage_r, auto_stage_nxt;
  logic [2:0]        pend_r,  pend_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [7:0]        pwm_r,   pwm_nxt;
  out_item_t         res_c;

  always_comb begin
    logic [1:0]        md;
    logic [3:0]        ms;
    logic [3:0]        as;
    logic [2:0]        pb;
    logic [TICK_W-1:0] tk;
    logic [7:0]        pw;
    logic [3:0]        st;
    logic              dl;
    logic              dr;
    logic              idle;

    md = mode_r;
    ms = man_stage_r;
    as = auto_stage_r;
    pw = pwm_r;
    st = STG_IDLE;
    dl = 1'b0;
    dr = 1'b0;
    pb = pend_r | {item.button_right, item.button_middle, item.button_left};

    if (item.mode_event) begin
      md = item.mode_switch ? MODE_AUTO : MODE_MANUAL;
      pb = 3'b000;
      ms = STG_IDLE;
      as = STG_IDLE;
    end

    // watchdog
    idle = (md == MODE_MANUAL && ms == STG_IDLE) || (md == MODE_AUTO && as == STG_IDLE);
    if (idle) begin
      tk = '0;
    end else if (ticks_r != TICK_MAX) begin
      tk = ticks_r + 1'b1;
    end else begin
      tk = ticks_r;
    end
    if (tk > {1'b0, cfg.alarm_timeout}) begin
      ms = STG_IDLE;
      as = STG_IDLE;
      md = MODE_ALARM;
    end

    if (md == MODE_MANUAL) begin
      if (ms == STG_IDLE) begin
        if (pb[0]) begin
          ms = STG_LEFT;
          pb[0] = 1'b0;
        end else if (pb[1]) begin
          ms = STG_MID_RUN;
          pb[1] = 1'b0;
        end else if (pb[2]) begin
          ms = STG_RIGHT;
          pb[2] = 1'b0;
        end
      end else begin
        ms = stage_advance(ms, item.left_end, item.right_end, item.middle_sensor);
      end
      st = ms;
      if (st == STG_LEFT || st == STG_MID_BACK) begin
        dl = 1'b1;
        pw = cfg.full_speed;
      end else if (st == STG_IDLE && item.jog_left && !item.jog_right && !item.left_end) begin
        dl = 1'b1;
        pw = cfg.jog_speed;
      end else if (st == STG_MID_RUN || st == STG_MID_SEEN || st == STG_RIGHT) begin
        dr = 1'b1;
        pw = cfg.full_speed;
      end else if (st == STG_IDLE && !item.jog_left && item.jog_right && !item.right_end) begin
        dr = 1'b1;
        pw = cfg.jog_speed;
      end
    end else if (md == MODE_AUTO) begin
      if (as == STG_IDLE) begin
        if (item.analog_level < cfg.left_threshold && !item.left_end) begin
          as = STG_LEFT;
        end else if (item.analog_level > cfg.middle_low &&
                     item.analog_level < cfg.middle_high && !item.middle_sensor) begin
          as = STG_MID_RUN;
        end else if (item.analog_level > cfg.right_threshold && !item.right_end) begin
          as = STG_RIGHT;
        end
      end else begin
        as = stage_advance(as, item.left_end, item.right_end, item.middle_sensor);
      end
      st = as;
      if (st == STG_LEFT || st == STG_MID_BACK) begin
        dl = 1'b1;
        pw = cfg.full_speed;
      end else if (st == STG_MID_RUN || st == STG_MID_SEEN || st == STG_RIGHT) begin
        dr = 1'b1;
        pw = cfg.full_speed;
      end
    end else begin
      pw = 8'd0;
      st = STG_IDLE;
    end

    mode_nxt          = md;
    man_stage_nxt     = ms;
    auto_stage_nxt    = as;
    pend_nxt          = pb;
    ticks_nxt         = tk;
    pwm_nxt           = pw;
    res_c.mode        = md;
    res_c.stage       = st;
    res_c.drive_left  = dl;
    res_c.drive_right = dr;
    res_c.pwm_compare = pw;
  end

  assign res = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MANUAL;
      man_stage_r  <= STG_IDLE;
      auto_stage_r <= STG_IDLE;
      pend_r       <= 3'b000;
      ticks_r      <= '0;
      pwm_r        <= RST_PWM_HOLD;
    end else if (step) begin
      mode_r       <= mode_nxt;
      man_stage_r  <= man_stage_nxt;
      auto_stage_r <= auto_stage_nxt;
      pend_r       <= pend_nxt;
      ticks_r      <= ticks_nxt;
      pwm_r        <= pwm_nxt;
    end
  end

  `CMSW_ASSERT_IMP(a_alarm_stages_idle, mode_r == MODE_ALARM, man_stage_r == STG_IDLE && auto_stage_r == STG_IDLE, "stage running in alarm")
  `CMSW_ASSERT_IMP(a_alarm_pwm_zero, mode_r == MODE_ALARM, pwm_r == 8'd0, "pwm hold nonzero in alarm")
  `CMSW_ASSERT_NXT(a_mode_event_mode, step && item.mode_event, mode_r == {1'b0, $past(item.mode_switch)}, "mode event did not select switch mode")

endmodule

`default_nettype wire

[hdl/cart_mode_sequencer_with_watchdog.sv]
// ----------------------------------------------------------------------------
// cart_mode_sequencer_with_watchdog
// Top level: input register, tick step logic, result register, config port.
// ----------------------------------------------------------------------------
// One request is one 1 ms tick and yields exactly one result. A request is
// taken every cycle while out_ready is high: it lands in an input register,
// the mode, stage, watchdog and PWM update happens in a single combinational
// pass from that register, and the result is held in an output register
// until taken, so throughput is one tick per cycle while out_ready is high.
// The config port is always ready; registers should be written only while no
// tick is in flight.
`default_nettype none

module cart_mode_sequencer_with_watchdog (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire cmsw_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output cmsw_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cmsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cmsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cmsw_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_vld_r;
  out_item_t out_item_r;
  logic      out_vld_r;
  out_item_t res;
  logic      adv;
  logic      step;

  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = !in_vld_r || adv;
  assign step      = in_vld_r && adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  cmsw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cmsw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (step) begin
      out_item_r <= res;
    end
  end

endmodule

`default_nettype wire

[dv/cart_mode_sequencer_with_watchdog_tb.sv]
// ----------------------------------------------------------------------------
// cart_mode_sequencer_with_watchdog_tb
// Self-checking bench for the cart mode sequencer. A table of directed ticks
// is followed by biased random ticks over several register settings, among
// them the extremes, a zero timeout and a long move under the largest
// timeout. Every result is checked against a tick-level predictor of mode,
// stage, drive bits and held PWM compare value, but for the typed directed rows, which carry their own expected values.
// ----------------------------------------------------------------------------
module cart_mode_sequencer_with_watchdog_tb;
  import cmsw_pkg::*;

  localparam int DIR_ROWS    = 26;
  localparam int MAX_SHOWN   = 10;
  localparam int STALL_LIMIT = 400;
  localparam int DRAIN_WAIT  = 4;
  localparam logic [16:0] NO_CHECK = '0;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [1:0]        cur_mode   = MODE_MANUAL;
  logic [3:0]        man_stg    = STG_IDLE;
  logic [3:0]        aut_stg    = STG_IDLE;
  logic [2:0]        btn_latch  = '0;
  logic [TICK_W-1:0] move_ticks = '0;
  logic [7:0]        pwm_q      = RST_PWM_HOLD;

  // register copies
  logic [7:0]  spd_full  = RST_FULL_SPEED;
  logic [7:0]  spd_jog   = RST_JOG_SPEED;
  logic [12:0] tmo       = RST_ALARM_TMO;
  logic [7:0]  thr_left  = RST_LEFT_THR;
  logic [7:0]  mid_lo    = RST_MIDDLE_LOW;
  logic [7:0]  mid_hi    = RST_MIDDLE_HIGH;
  logic [7:0]  thr_right = RST_RIGHT_THR;

  out_item_t want_results[$];
  int        bad_results  = 0;
  int        stall_cycles = 0;
  int        rx_sel       = 0;
  int        rx_cyc       = 0;
  bit        tx_steady    = 1'b0;
  int        burst_left   = 0;
  int        ev_pct       = 3;
  int        btn_pct      = 8;
  int        sens_pct     = 15;
  int        jog_pct      = 30;

  cart_mode_sequencer_with_watchdog i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [3:0] sensor_step(input logic [3:0] st, input logic le,
                                             input logic re, input logic mid);
    logic [3:0] nxt;
    nxt = st;
    if (st == STG_LEFT && le) begin
      nxt = STG_IDLE;
    end else if (st == STG_MID_RUN) begin
      if (mid) nxt = STG_MID_SEEN;
      else if (re) nxt = STG_MID_BACK;
    end else if (st == STG_MID_SEEN && !mid) begin
      nxt = STG_MID_BACK;
    end else if (st == STG_MID_BACK && mid) begin
      nxt = STG_IDLE;
    end else if (st == STG_RIGHT && re) begin
      nxt = STG_IDLE;
    end
    return nxt;
  endfunction

  function automatic out_item_t predict_tick(input in_item_t t);
    out_item_t  r;
    logic [3:0] st;
    logic       dl;
    logic       dr;
    dl = 1'b0;
    dr = 1'b0;
    st = STG_IDLE;
    btn_latch = btn_latch | {t.button_right, t.button_middle, t.button_left};
    if (t.mode_event) begin
      cur_mode  = t.mode_switch ? MODE_AUTO : MODE_MANUAL;
      btn_latch = '0;
      man_stg   = STG_IDLE;
      aut_stg   = STG_IDLE;
    end
    if ((cur_mode == MODE_MANUAL && man_stg == STG_IDLE) ||
        (cur_mode == MODE_AUTO && aut_stg == STG_IDLE)) begin
      move_ticks = '0;
    end else if (move_ticks != TICK_MAX) begin
      move_ticks = move_ticks + 1'b1;
    end
    if (move_ticks > {1'b0, tmo}) begin
      man_stg  = STG_IDLE;
      aut_stg  = STG_IDLE;
      cur_mode = MODE_ALARM;
    end
    if (cur_mode == MODE_MANUAL) begin
      if (man_stg == STG_IDLE) begin
        if (btn_latch[0]) begin
          man_stg = STG_LEFT;
          btn_latch[0] = 1'b0;
        end else if (btn_latch[1]) begin
          man_stg = STG_MID_RUN;
          btn_latch[1] = 1'b0;
        end else if (btn_latch[2]) begin
          man_stg = STG_RIGHT;
          btn_latch[2] = 1'b0;
        end
      end else begin
        man_stg = sensor_step(man_stg, t.left_end, t.right_end, t.middle_sensor);
      end
      st = man_stg;
      if (st == STG_LEFT || st == STG_MID_BACK) begin
        dl = 1'b1;
        pwm_q = spd_full;
      end else if (st == STG_IDLE && t.jog_left && !t.jog_right && !t.left_end) begin
        dl = 1'b1;
        pwm_q = spd_jog;
      end else if (st == STG_MID_RUN || st == STG_MID_SEEN || st == STG_RIGHT) begin
        dr = 1'b1;
        pwm_q = spd_full;
      end else if (st == STG_IDLE && !t.jog_left && t.jog_right && !t.right_end) begin
        dr = 1'b1;
        pwm_q = spd_jog;
      end
    end else if (cur_mode == MODE_AUTO) begin
      if (aut_stg == STG_IDLE) begin
        if (t.analog_level < thr_left && !t.left_end) begin
          aut_stg = STG_LEFT;
        end else if (t.analog_level > mid_lo && t.analog_level < mid_hi &&
                     !t.middle_sensor) begin
          aut_stg = STG_MID_RUN;
        end else if (t.analog_level > thr_right && !t.right_end) begin
          aut_stg = STG_RIGHT;
        end
      end else begin
        aut_stg = sensor_step(aut_stg, t.left_end, t.right_end, t.middle_sensor);
      end
      st = aut_stg;
      if (st == STG_LEFT || st == STG_MID_BACK) begin
        dl = 1'b1;
        pwm_q = spd_full;
      end else if (st == STG_MID_RUN || st == STG_MID_SEEN || st == STG_RIGHT) begin
        dr = 1'b1;
        pwm_q = spd_full;
      end
    end else begin
      pwm_q = '0;
    end
    r.mode        = cur_mode;
    r.stage       = st;
    r.drive_left  = dl;
    r.drive_right = dr;
    r.pwm_compare = pwm_q;
    return r;
  endfunction

  // fields: switch, event, buttons L/M/R, sensors left/right/middle, jog L/R, analog
  function automatic dir_row_t directed_row(input int idx);
    case (idx)
      0:  return {1'b0, 1'b0, 3'b000, 3'b000, 2'b00, 8'd0,
                  1'b1, MODE_MANUAL, STG_IDLE, 2'b00, RST_PWM_HOLD};
      1:  return {1'b0, 1'b0, 3'b000, 3'b000, 2'b10, 8'd255,
                  1'b1, MODE_MANUAL, STG_IDLE, 2'b10, RST_JOG_SPEED};
      2:  return {1'b0, 1'b0, 3'b000, 3'b000, 2'b11, 8'd0,
                  1'b1, MODE_MANUAL, STG_IDLE, 2'b00, RST_JOG_SPEED};
      3:  return {1'b0, 1'b0, 3'b000, 3'b010, 2'b01, 8'd0,
                  1'b1, MODE_MANUAL, STG_IDLE, 2'b00, RST_JOG_SPEED};
      4:  return {1'b0, 1'b0, 3'b000, 3'b100, 2'b10, 8'd0,
                  1'b1, MODE_MANUAL, STG_IDLE, 2'b00, RST_JOG_SPEED};
      5:  return {1'b0, 1'b0, 3'b000, 3'b000, 2'b01, 8'd0,
                  1'b1, MODE_MANUAL, STG_IDLE, 2'b01, RST_JOG_SPEED};
      6:  return {1'b0, 1'b0, 3'b100, 3'b000, 2'b00, 8'd0,
                  1'b1, MODE_MANUAL, STG_LEFT, 2'b10, RST_FULL_SPEED};
      7:  return {1'b0, 1'b0, 3'b000, 3'b000, 2'b00, 8'd0, NO_CHECK};
      8:  return {1'b0, 1'b0, 3'b000, 3'b100, 2'b00, 8'd0, NO_CHECK};
      9:  return {1'b0, 1'b0, 3'b111, 3'b000, 2'b00, 8'd0, NO_CHECK};
      10: return {1'b0, 1'b0, 3'b000, 3'b100, 2'b00, 8'd0, NO_CHECK};
      11: return {1'b0, 1'b0, 3'b000, 3'b000, 2'b00, 8'd0, NO_CHECK};
      12: return {1'b0, 1'b0, 3'b000, 3'b001, 2'b00, 8'd0, NO_CHECK};
      13: return {1'b0, 1'b0, 3'b000, 3'b000, 2'b00, 8'd0, NO_CHECK};
      14: return {1'b0, 1'b0, 3'b000, 3'b001, 2'b00, 8'd0, NO_CHECK};
      15: return {1'b0, 1'b0, 3'b000, 3'b000, 2'b00, 8'd0, NO_CHECK};
      16: return {1'b0, 1'b0, 3'b000, 3'b010, 2'b00, 8'd0, NO_CHECK};
      17: return {1'b1, 1'b1, 3'b100, 3'b010, 2'b00, 8'd255, NO_CHECK};
      18: return {1'b1, 1'b0, 3'b000, 3'b000, 2'b00, 8'd0, NO_CHECK};
      19: return {1'b1, 1'b0, 3'b000, 3'b100, 2'b00, 8'd0, NO_CHECK};
      20: return {1'b1, 1'b0, 3'b000, 3'b000, 2'b00, 8'd255, NO_CHECK};
      21: return {1'b1, 1'b0, 3'b000, 3'b010, 2'b00, 8'd128, NO_CHECK};
      22: return {1'b1, 1'b0, 3'b000, 3'b000, 2'b00, 8'd128, NO_CHECK};
      23: return {1'b0, 1'b1, 3'b010, 3'b000, 2'b00, 8'd128, NO_CHECK};
      24: return {1'b1, 1'b1, 3'b000, 3'b000, 2'b00, 8'd75, NO_CHECK};
      default: return {1'b1, 1'b0, 3'b000, 3'b000, 2'b00, 8'd195, NO_CHECK};
    endcase
  endfunction

  function automatic in_item_t random_tick();
    in_item_t t;
    t.mode_switch   = 1'($urandom_range(0, 1));
    t.mode_event    = ($urandom_range(0, 99) < ev_pct);
    t.button_left   = ($urandom_range(0, 99) < btn_pct);
    t.button_middle = ($urandom_range(0, 99) < btn_pct);
    t.button_right  = ($urandom_range(0, 99) < btn_pct);
    t.left_end      = ($urandom_range(0, 99) < sens_pct);
    t.right_end     = ($urandom_range(0, 99) < sens_pct);
    t.middle_sensor = ($urandom_range(0, 99) < sens_pct);
    t.jog_left      = ($urandom_range(0, 99) < jog_pct);
    t.jog_right     = ($urandom_range(0, 99) < jog_pct);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 7))
          0: t.analog_level = thr_left - 8'd1;
          1: t.analog_level = thr_left;
          2: t.analog_level = mid_lo;
          3: t.analog_level = mid_lo + 8'd1;
          4: t.analog_level = mid_hi - 8'd1;
          5: t.analog_level = mid_hi;
          6: t.analog_level = thr_right;
          default: t.analog_level = thr_right + 8'd1;
        endcase
      end
      1: t.analog_level = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: t.analog_level = 8'($urandom_range(0, 255));
    endcase
    return t;
  endfunction

  task automatic push_tick(input in_item_t t, input logic typed, input out_item_t want);
    out_item_t pred;
    int        gap;
    if (!tx_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    pred = predict_tick(t);
    want_results.push_back(typed ? want : pred);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (want_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FULL_SPEED:  spd_full  = d[7:0];
      CFG_JOG_SPEED:   spd_jog   = d[7:0];
      CFG_ALARM_TMO:   tmo       = d[12:0];
      CFG_LEFT_THR:    thr_left  = d[7:0];
      CFG_MIDDLE_LOW:  mid_lo    = d[7:0];
      CFG_MIDDLE_HIGH: mid_hi    = d[7:0];
      CFG_RIGHT_THR:   thr_right = d[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [12:0] full, input logic [12:0] jog,
                           input logic [12:0] to, input logic [12:0] tl,
                           input logic [12:0] ml, input logic [12:0] mh,
                           input logic [12:0] tr);
    wait_all_results();
    write_reg(CFG_FULL_SPEED, full);
    write_reg(CFG_JOG_SPEED, jog);
    write_reg(CFG_ALARM_TMO, to);
    write_reg(CFG_LEFT_THR, tl);
    write_reg(CFG_MIDDLE_LOW, ml);
    write_reg(CFG_MIDDLE_HIGH, mh);
    write_reg(CFG_RIGHT_THR, tr);
  endtask

  task automatic random_ticks(input int n, input int rx, input bit steady);
    rx_sel    = rx;
    tx_steady = steady;
    repeat (n) push_tick(random_tick(), 1'b0, '0);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    rx_cyc++;
    case (rx_sel)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 6);
      default: out_ready <= ((rx_cyc % 11) > 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (want_results.size() == 0) begin
          if (bad_results < MAX_SHOWN)
            $display("unexpected result: mode=%0d stage=%0d dl=%0b dr=%0b pwm=%0d",
                     out_data.mode, out_data.stage, out_data.drive_left,
                     out_data.drive_right, out_data.pwm_compare);
          bad_results++;
        end else if (out_data.mode != want_results[0].mode ||
                     out_data.stage != want_results[0].stage ||
                     out_data.drive_left != want_results[0].drive_left ||
                     out_data.drive_right != want_results[0].drive_right ||
                     out_data.pwm_compare != want_results[0].pwm_compare) begin
          if (bad_results < MAX_SHOWN)
            $display("mismatch mode/stage/dl/dr/pwm exp %0d/%0d/%0b/%0b/%0d got %0d/%0d/%0b/%0b/%0d",
                     want_results[0].mode, want_results[0].stage,
                     want_results[0].drive_left, want_results[0].drive_right,
                     want_results[0].pwm_compare, out_data.mode, out_data.stage,
                     out_data.drive_left, out_data.drive_right, out_data.pwm_compare);
          bad_results++;
          void'(want_results.pop_front());
        end else begin
          void'(want_results.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    in_item_t t;
    int       i;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: directed table, then random
    for (i = 0; i < DIR_ROWS; i++) begin
      row = directed_row(i);
      push_tick(row.stim, row.typed, row.want);
    end
    random_ticks(60, 0, 1'b0);

    // short timeout, alarms are frequent
    load_regs(13'd140, 13'd99, 13'd12, 13'd75, 13'd95, 13'd175, 13'd195);
    random_ticks(60, 1, 1'b0);

    // all minimums, but for a timeout of 1
    load_regs(13'd0, 13'd0, 13'd1, 13'd0, 13'd0, 13'd0, 13'd0);
    random_ticks(60, 2, 1'b1);

    // all ones: masked maximums, longest timeout
    load_regs(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    rx_sel = 1;
    t = '0;
    t.mode_event = 1'b1;
    push_tick(t, 1'b0, '0);
    t = '0;
    t.button_right = 1'b1;
    push_tick(t, 1'b0, '0);
    // right move never sees the end sensor and keeps running
    repeat (40) begin
      t = '0;
      t.analog_level = 8'($urandom_range(0, 255));
      push_tick(t, 1'b0, '0);
    end
    random_ticks(60, 1, 1'b0);

    // zero timeout: any move lasts one tick
    load_regs(13'd180, 13'd20, 13'd0, 13'd60, 13'd100, 13'd160, 13'd200);
    random_ticks(60, 0, 1'b1);

    repeat (3) begin
      load_regs(13'($urandom_range(0, 199)), 13'($urandom_range(0, 199)),
                13'($urandom_range(3, 60)), 13'($urandom_range(0, 255)),
                13'($urandom_range(0, 255)), 13'($urandom_range(0, 255)),
                13'($urandom_range(0, 255)));
      random_ticks(60, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
    end

    wait_all_results();
    if (bad_results == 0 && want_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
